// File: sv/echist_pkg.sv
// ----------------------------------------------------------------------------
// echist_pkg
// Shared types and constants for the exit cause latency histogram.
// ----------------------------------------------------------------------------
package echist_pkg;

  localparam int NUM_BINS    = 256;
  localparam int NUM_CPUS    = 4;
  localparam int COUNT_WIDTH = 32;
  localparam int TIME_WIDTH  = 48;
  localparam int BIN_W       = $clog2(NUM_BINS);
  localparam int CPU_W       = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int US_DIV      = 1000;

  // floor(x / 1000) == (x * US_DIV_RECIP) >> 28 for x below 256000
  localparam logic [18:0] US_DIV_RECIP = 19'd268436;

  typedef logic [2:0] op_t;
  localparam op_t OP_EXIT        = 3'd0;
  localparam op_t OP_FAULT_START = 3'd1;
  localparam op_t OP_FAULT_END   = 3'd2;
  localparam op_t OP_EXIT_START  = 3'd3;
  localparam op_t OP_EXIT_END    = 3'd4;
  localparam op_t OP_CLEAR       = 3'd5;
  localparam op_t OP_READ        = 3'd6;

  typedef logic [1:0] sel_t;
  localparam sel_t SEL_HCALL = 2'd0;
  localparam sel_t SEL_TRAP  = 2'd1;
  localparam sel_t SEL_FAULT = 2'd2;
  localparam sel_t SEL_EXIT  = 2'd3;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_NONE  = 2'd0;
  localparam kind_t KIND_HCALL = 2'd1;
  localparam kind_t KIND_TRAP  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_HCALL_VEC = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_HCALL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TRAP  = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_DIV, ST_READ, ST_WRITE, ST_OUT
  } state_t;

  typedef struct packed {
    logic            start;
    logic [63:0]     dividend;
  } div_req_t;

  function automatic logic [BIN_W-1:0] fit_bin(input logic [63:0] v);
    return (v > 64'(NUM_BINS - 1)) ? BIN_W'(NUM_BINS - 1) : v[BIN_W-1:0];
  endfunction

endpackage

// File: sv/echist_div.sv
// ----------------------------------------------------------------------------
// echist_div
// Divide by 1000, one quotient byte per cycle by reciprocal multiplication.
// ----------------------------------------------------------------------------
module echist_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  echist_pkg::div_req_t  req,
  output logic                  done,
  output logic [63:0]           quotient
);
  import echist_pkg::*;

  logic [63:0] x_r, x_nxt;
  logic [63:0] q_r, q_nxt;
  logic [9:0]  rem_r, rem_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [17:0] part;
  logic [36:0] prod;
  logic [7:0]  qd;
  logic [17:0] qd_x;
  logic [17:0] rest;

  always_comb begin
    part     = {rem_r, x_r[63:56]};
    prod     = {19'd0, part} * {18'd0, US_DIV_RECIP};
    qd       = prod[35:28];
    qd_x     = {qd, 10'd0} - {5'd0, qd, 5'd0} + {7'd0, qd, 3'd0};
    rest     = part - qd_x;
    x_nxt    = x_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (req.start) begin
      x_nxt    = req.dividend;
      q_nxt    = '0;
      rem_nxt  = '0;
      cnt_nxt  = 4'd8;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (cnt_r != 4'd0) begin
        x_nxt   = {x_r[55:0], 8'd0};
        q_nxt   = {q_r[55:0], qd};
        rem_nxt = rest[9:0];
        cnt_nxt = cnt_r - 4'd1;
      end else begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    x_r   <= x_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
  end

  assign done     = busy_r && (cnt_r == 4'd0);
  assign quotient = q_r;
endmodule

// File: sv/exit_cause_latency_histogram.sv
// ----------------------------------------------------------------------------
// exit_cause_latency_histogram
// Guest exit monitor: cause counters, time totals and latency histograms.
// ----------------------------------------------------------------------------
// One transaction at a time. Start events finish on accept; exits read, then write.
// Reads read the bin, latch the result, then hold it on the output until taken.
// Fault and exit ends first run the 8-step divide by 1000; an exit end without
// a start stamp is dropped. Clear sweeps the 256 bins of the selected table.
// After reset a clearing pass runs through all bin memories before input is taken.
module exit_cause_latency_histogram (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_op,
  input  logic [1:0]  in_cpu_id,
  input  logic [7:0]  in_trap_number,
  input  logic [63:0] in_hypercall_number,
  input  logic [63:0] in_timestamp_ns,
  input  logic [1:0]  in_table_select,
  input  logic [7:0]  in_bin_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_count_value,
  output logic [47:0] out_time_total_us,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import echist_pkg::*;

  logic [COUNT_WIDTH-1:0] hc_cnt_mem [NUM_BINS];
  logic [COUNT_WIDTH-1:0] tr_cnt_mem [NUM_BINS];
  logic [TIME_WIDTH-1:0]  hc_tm_mem  [NUM_BINS];
  logic [TIME_WIDTH-1:0]  tr_tm_mem  [NUM_BINS];
  logic [COUNT_WIDTH-1:0] fl_mem     [NUM_BINS];
  logic [COUNT_WIDTH-1:0] ex_mem     [NUM_BINS];

  logic [7:0] hvec_r, maxh_r, maxt_r;
  logic [63:0] fstart_r [NUM_CPUS];
  logic [63:0] estart_r [NUM_CPUS];
  kind_t       kind_r   [NUM_CPUS];
  logic [7:0]  cidx_r   [NUM_CPUS];

  state_t state_r, state_nxt;
  op_t    op_r;
  sel_t   sel_r;
  logic [BIN_W-1:0] a_r, b_r, clr_r;
  logic   hc_en_r, tr_en_r, hit_r;
  logic [63:0] d_r;
  kind_t  ekind_r;
  logic [COUNT_WIDTH-1:0] out_cnt_r;
  logic [TIME_WIDTH-1:0]  out_tm_r;

  logic [COUNT_WIDTH-1:0] rd_hc_c, rd_tr_c, rd_fl, rd_ex;
  logic [TIME_WIDTH-1:0]  rd_hc_t, rd_tr_t;

  div_req_t    dreq;
  logic        ddone;
  logic [63:0] dq;

  echist_div u_div (.clk, .rst_n, .req(dreq), .done(ddone), .quotient(dq));

  logic accept;
  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = (state_r == ST_OUT);
  assign out_count_value   = out_cnt_r;
  assign out_time_total_us = out_tm_r;

  logic [63:0] hnum_cl;
  logic [7:0]  trap_cl;
  always_comb begin
    hnum_cl = (in_hypercall_number > 64'(maxh_r)) ? 64'(maxh_r) : in_hypercall_number;
    trap_cl = (in_trap_number >= maxt_r) ? maxt_r : in_trap_number;
    dreq.start    = 1'b0;
    dreq.dividend = '0;
    if (accept && in_op == OP_FAULT_END) begin
      dreq.start    = 1'b1;
      dreq.dividend = in_timestamp_ns - fstart_r[in_cpu_id];
    end else if (accept && in_op == OP_EXIT_END) begin
      dreq.start    = estart_r[in_cpu_id] != '0;
      dreq.dividend = in_timestamp_ns - estart_r[in_cpu_id];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_r == BIN_W'(NUM_BINS - 1)) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          unique case (in_op)
            OP_EXIT:      state_nxt = ST_READ;
            OP_FAULT_END: state_nxt = ST_DIV;
            OP_EXIT_END:  state_nxt = dreq.start ? ST_DIV : ST_IDLE;
            OP_CLEAR:     state_nxt = ST_CLEAR;
            OP_READ:      state_nxt = ST_READ;
            default:      state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_DIV:   if (ddone) state_nxt = ST_READ;
      ST_READ:  state_nxt = ST_WRITE;
      ST_WRITE: state_nxt = (op_r == OP_READ) ? ST_OUT : ST_IDLE;
      ST_OUT:   if (!out_stall) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      op_r    <= OP_EXIT;
      clr_r   <= '0;
      hvec_r  <= 8'd31;
      maxh_r  <= 8'd63;
      maxt_r  <= 8'd63;
      for (int i = 0; i < NUM_CPUS; i++) begin
        fstart_r[i] <= '0;
        estart_r[i] <= '0;
        kind_r[i]   <= KIND_NONE;
        cidx_r[i]   <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_HCALL_VEC: hvec_r <= cfg_data;
          CFG_MAX_HCALL: maxh_r <= cfg_data;
          CFG_MAX_TRAP:  maxt_r <= cfg_data;
          default: ;
        endcase
      end
      if (state_r == ST_CLEAR) begin
        clr_r <= clr_r + BIN_W'(1);
        if (clr_r == BIN_W'(NUM_BINS - 1)) op_r <= OP_CLEAR;
      end
      if (accept) begin
        op_r  <= in_op;
        clr_r <= '0;
        case (in_op)
          OP_EXIT: begin
            if (in_trap_number == hvec_r) begin
              kind_r[in_cpu_id] <= KIND_HCALL;
              cidx_r[in_cpu_id] <= hnum_cl[7:0];
            end else begin
              kind_r[in_cpu_id] <= KIND_TRAP;
              cidx_r[in_cpu_id] <= in_trap_number;
            end
          end
          OP_FAULT_START: fstart_r[in_cpu_id] <= in_timestamp_ns;
          OP_EXIT_START:
            estart_r[in_cpu_id] <= (in_timestamp_ns == '0) ? 64'd1 : in_timestamp_ns;
          OP_EXIT_END: if (dreq.start) kind_r[in_cpu_id] <= KIND_NONE;
          default: ;
        endcase
      end
    end
  end

  // latch transaction payload
  always_ff @(posedge clk) begin
    if (accept) begin
      sel_r   <= (in_op == OP_CLEAR || in_op == OP_READ) ? in_table_select : SEL_HCALL;
      hit_r   <= 1'b1;
      hc_en_r <= 1'b0;
      tr_en_r <= 1'b0;
      ekind_r <= kind_r[in_cpu_id];
      case (in_op)
        OP_EXIT: begin
          hc_en_r <= in_trap_number == hvec_r;
          tr_en_r <= 1'b1;
          a_r     <= fit_bin(hnum_cl);
          b_r     <= fit_bin(64'(trap_cl));
        end
        OP_EXIT_END: begin
          hc_en_r <= kind_r[in_cpu_id] == KIND_HCALL;
          tr_en_r <= kind_r[in_cpu_id] == KIND_HCALL || kind_r[in_cpu_id] == KIND_TRAP;
          a_r     <= fit_bin(64'(cidx_r[in_cpu_id]));
          b_r     <= (kind_r[in_cpu_id] == KIND_HCALL) ? fit_bin(64'(hvec_r))
                                                       : fit_bin(64'(cidx_r[in_cpu_id]));
        end
        OP_READ: begin
          hit_r <= 64'(in_bin_index) < 64'(NUM_BINS);
          a_r   <= in_bin_index[BIN_W-1:0];
          b_r   <= in_bin_index[BIN_W-1:0];
        end
        default: ;
      endcase
    end
    if (state_r == ST_DIV && ddone) begin
      d_r <= dq;
      if (op_r == OP_FAULT_END) a_r <= fit_bin(dq);
    end
    if (state_r == ST_WRITE && op_r == OP_READ) begin
      out_cnt_r <= '0;
      out_tm_r  <= '0;
      if (hit_r) begin
        case (sel_r)
          SEL_HCALL: begin out_cnt_r <= rd_hc_c; out_tm_r <= rd_hc_t; end
          SEL_TRAP:  begin out_cnt_r <= rd_tr_c; out_tm_r <= rd_tr_t; end
          SEL_FAULT: out_cnt_r <= rd_fl;
          default:   out_cnt_r <= rd_ex;
        endcase
      end
    end
  end

  // histogram bins come from the quotient; a_r/b_r keep cause bins on exit ends
  logic [BIN_W-1:0] dbin;
  assign dbin = fit_bin(d_r);

  // read addresses: histogram bins follow the quotient while dividing
  logic [BIN_W-1:0] ra_hc, ra_tr, ra_fl, ra_ex;
  always_comb begin
    ra_hc = a_r;
    ra_tr = b_r;
    ra_fl = (op_r == OP_FAULT_END) ? fit_bin(dq) : a_r;
    ra_ex = (op_r == OP_EXIT_END) ? fit_bin(dq) : a_r;
  end

  logic wr;
  assign wr = (state_r == ST_WRITE);

  always_ff @(posedge clk) begin
    rd_hc_c <= hc_cnt_mem[ra_hc];
    rd_hc_t <= hc_tm_mem[ra_hc];
    rd_tr_c <= tr_cnt_mem[ra_tr];
    rd_tr_t <= tr_tm_mem[ra_tr];
    if (state_r == ST_DIV || state_r == ST_IDLE) begin
      rd_fl <= fl_mem[ra_fl];
      rd_ex <= ex_mem[ra_ex];
    end else begin
      rd_fl <= fl_mem[a_r];
      rd_ex <= ex_mem[(op_r == OP_EXIT_END) ? dbin : a_r];
    end
    if (state_r == ST_CLEAR) begin
      if (op_r != OP_CLEAR || sel_r == SEL_HCALL) begin
        hc_cnt_mem[clr_r] <= '0;
        hc_tm_mem[clr_r]  <= '0;
      end
      if (op_r != OP_CLEAR || sel_r == SEL_TRAP) begin
        tr_cnt_mem[clr_r] <= '0;
        tr_tm_mem[clr_r]  <= '0;
      end
      if (op_r != OP_CLEAR || sel_r == SEL_FAULT) fl_mem[clr_r] <= '0;
      if (op_r != OP_CLEAR || sel_r == SEL_EXIT)  ex_mem[clr_r] <= '0;
    end
    if (wr) begin
      case (op_r)
        OP_EXIT: begin
          if (hc_en_r) hc_cnt_mem[a_r] <= rd_hc_c + COUNT_WIDTH'(1);
          tr_cnt_mem[b_r] <= rd_tr_c + COUNT_WIDTH'(1);
        end
        OP_FAULT_END: fl_mem[dbin] <= rd_fl + COUNT_WIDTH'(1);
        OP_EXIT_END: begin
          if (hc_en_r) hc_tm_mem[a_r] <= rd_hc_t + d_r[TIME_WIDTH-1:0];
          if (tr_en_r) tr_tm_mem[b_r] <= rd_tr_t + d_r[TIME_WIDTH-1:0];
          ex_mem[dbin] <= rd_ex + COUNT_WIDTH'(1);
        end
        default: ;
      endcase
    end
  end
endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// exit_cause_latency_histogram testbench
// Drives exit, start/end, clear and read transactions into the monitor while
// a scoreboard mirrors every table, and compares each read result field by
// field against the mirrored bin. The input idles and the output stalls at random.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import echist_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_op = '0;
  logic [1:0]  in_cpu_id = '0;
  logic [7:0]  in_trap_number = '0;
  logic [63:0] in_hypercall_number = '0;
  logic [63:0] in_timestamp_ns = '0;
  logic [1:0]  in_table_select = '0;
  logic [7:0]  in_bin_index = '0;
  logic        out_valid;
  logic        out_stall = 1'b1;
  logic [31:0] out_count_value;
  logic [47:0] out_time_total_us;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;

  exit_cause_latency_histogram dut (.*);

  always #6 clk = ~clk;

  typedef struct {
    logic [31:0] cnt;
    logic [47:0] tm;
  } bin_read_t;

  logic [7:0]  hcall_vec, max_hcall, max_trap;
  logic [63:0] fault_stamp [NUM_CPUS];
  logic [63:0] exit_stamp [NUM_CPUS];
  kind_t       last_kind [NUM_CPUS];
  logic [7:0]  last_idx [NUM_CPUS];
  logic [31:0] hcall_cnt [NUM_BINS];
  logic [31:0] trap_cnt [NUM_BINS];
  logic [47:0] hcall_tm [NUM_BINS];
  logic [47:0] trap_tm [NUM_BINS];
  logic [31:0] fault_hist [NUM_BINS];
  logic [31:0] exit_hist [NUM_BINS];

  bin_read_t   pending_reads [$];
  int          errors = 0;
  int          idle_cycles = 0;
  int          stall_left = 0;
  logic [63:0] now_ns = 64'd5000;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic logic [7:0] bin_of(input logic [63:0] v);
    return (v > 64'(NUM_BINS - 1)) ? 8'(NUM_BINS - 1) : v[7:0];
  endfunction

  task automatic predict(input op_t op, input logic [1:0] cpu, input logic [7:0] trap,
                         input logic [63:0] hnum, input logic [63:0] ts,
                         input sel_t sel, input logic [7:0] bin);
    logic [63:0] h, t, d;
    bin_read_t r;
    case (op)
      OP_EXIT: begin
        if (trap == hcall_vec) begin
          h = (hnum > 64'(max_hcall)) ? 64'(max_hcall) : hnum;
          hcall_cnt[bin_of(h)]++;
          last_kind[cpu] = KIND_HCALL;
          last_idx[cpu] = h[7:0];
        end else begin
          last_kind[cpu] = KIND_TRAP;
          last_idx[cpu] = trap;
        end
        t = (trap >= max_trap) ? 64'(max_trap) : 64'(trap);
        trap_cnt[bin_of(t)]++;
      end
      OP_FAULT_START: fault_stamp[cpu] = ts;
      OP_FAULT_END: begin
        d = (ts - fault_stamp[cpu]) / 64'(US_DIV);
        fault_hist[bin_of(d)]++;
      end
      OP_EXIT_START: exit_stamp[cpu] = (ts == 0) ? 64'd1 : ts;
      OP_EXIT_END: begin
        if (exit_stamp[cpu] != 0) begin
          d = (ts - exit_stamp[cpu]) / 64'(US_DIV);
          if (last_kind[cpu] == KIND_HCALL) begin
            hcall_tm[bin_of(64'(last_idx[cpu]))] += d[47:0];
            trap_tm[bin_of(64'(hcall_vec))] += d[47:0];
          end else if (last_kind[cpu] == KIND_TRAP) begin
            trap_tm[bin_of(64'(last_idx[cpu]))] += d[47:0];
          end
          last_kind[cpu] = KIND_NONE;
          exit_hist[bin_of(d)]++;
        end
      end
      OP_CLEAR: begin
        for (int i = 0; i < NUM_BINS; i++) begin
          case (sel)
            SEL_HCALL: begin hcall_cnt[i] = 0; hcall_tm[i] = 0; end
            SEL_TRAP: begin trap_cnt[i] = 0; trap_tm[i] = 0; end
            SEL_FAULT: fault_hist[i] = 0;
            default: exit_hist[i] = 0;
          endcase
        end
      end
      OP_READ: begin
        r.tm = 0;
        case (sel)
          SEL_HCALL: begin r.cnt = hcall_cnt[bin]; r.tm = hcall_tm[bin]; end
          SEL_TRAP: begin r.cnt = trap_cnt[bin]; r.tm = trap_tm[bin]; end
          SEL_FAULT: r.cnt = fault_hist[bin];
          default: r.cnt = exit_hist[bin];
        endcase
        pending_reads.push_back(r);
      end
      default: ;
    endcase
  endtask

  task automatic random_gap();
    int n;
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    if (n != 0) in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic send_item(input op_t op, input logic [1:0] cpu, input logic [7:0] trap,
                           input logic [63:0] hnum, input logic [63:0] ts,
                           input sel_t sel, input logic [7:0] bin);
    random_gap();
    in_valid <= 1'b1;
    in_op <= op;
    in_cpu_id <= cpu;
    in_trap_number <= trap;
    in_hypercall_number <= hnum;
    in_timestamp_ns <= ts;
    in_table_select <= sel;
    in_bin_index <= bin;
    do @(posedge clk); while (in_stall);
    predict(op, cpu, trap, hnum, ts, sel, bin);
  endtask

  task automatic read_bin(input sel_t sel, input logic [7:0] bin);
    send_item(OP_READ, 0, 0, 0, 0, sel, bin);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_HCALL_VEC: hcall_vec = val;
      CFG_MAX_HCALL: max_hcall = val;
      default: max_trap = val;
    endcase
    @(posedge clk);
  endtask

  task automatic drain();
    int n;
    n = 0;
    in_valid <= 1'b0;
    while (pending_reads.size() != 0 && n < 200000) begin
      @(posedge clk);
      n++;
    end
    repeat (400) @(posedge clk);
  endtask

  task automatic random_hnum(output logic [63:0] h);
    case ($urandom_range(0, 3))
      0: h = {$urandom, $urandom};
      1: h = 64'($urandom_range(0, 300));
      2: h = 64'hFFFF_FFFF_FFFF_FFFF;
      default: h = 64'($urandom_range(0, 80));
    endcase
  endtask

  task automatic random_delta(output logic [63:0] d);
    case ($urandom_range(0, 5))
      0: d = 64'($urandom_range(0, 999));
      1: d = 64'($urandom_range(1000, 300000));
      2: d = {$urandom, $urandom};
      default: d = 64'($urandom_range(0, 80000));
    endcase
  endtask

  task automatic test_directed();
    logic [63:0] all1;
    all1 = 64'hFFFF_FFFF_FFFF_FFFF;
    send_item(OP_EXIT_END, 1, 0, 0, 64'd12345, SEL_EXIT, 0);
    send_item(OP_EXIT, 0, 8'd31, 64'd5, 0, SEL_HCALL, 0);
    send_item(OP_EXIT, 1, 8'd31, all1, 0, SEL_HCALL, 0);
    send_item(OP_EXIT, 2, 8'd255, 0, 0, SEL_HCALL, 0);
    send_item(OP_EXIT, 3, 8'd63, 0, 0, SEL_HCALL, 0);
    send_item(OP_EXIT_START, 0, 0, 0, 64'd0, SEL_HCALL, 0);
    send_item(OP_EXIT_END, 0, 0, 0, 64'd7001, SEL_HCALL, 0);
    send_item(OP_EXIT_START, 2, 0, 0, 64'd90000, SEL_HCALL, 0);
    send_item(OP_EXIT_END, 2, 0, 0, 64'd1000, SEL_HCALL, 0);
    send_item(OP_EXIT_END, 2, 0, 0, 64'd95000, SEL_HCALL, 0);
    send_item(OP_FAULT_END, 3, 0, 0, all1, SEL_HCALL, 0);
    send_item(OP_FAULT_START, 1, 0, 0, 64'd1000, SEL_HCALL, 0);
    send_item(OP_FAULT_END, 1, 0, 0, 64'd1999, SEL_HCALL, 0);
    send_item(op_t'(3'd7), 0, 0, 0, 0, SEL_HCALL, 0);
    read_bin(SEL_HCALL, 8'd5);
    read_bin(SEL_HCALL, 8'd63);
    read_bin(SEL_TRAP, 8'd63);
    read_bin(SEL_TRAP, 8'd31);
    read_bin(SEL_TRAP, 8'd255);
    read_bin(SEL_FAULT, 8'd255);
    read_bin(SEL_FAULT, 8'd0);
    read_bin(SEL_EXIT, 8'd7);
    read_bin(SEL_EXIT, 8'd255);
    send_item(OP_CLEAR, 0, 0, 0, 0, SEL_TRAP, 0);
    read_bin(SEL_TRAP, 8'd63);
    drain();
  endtask

  task automatic test_random(input int items);
    op_t op;
    logic [1:0] cpu;
    logic [63:0] h, d;
    int k;
    for (int i = 0; i < items; i++) begin
      cpu = 2'($urandom_range(0, 3));
      random_hnum(h);
      random_delta(d);
      k = $urandom_range(0, 99);
      if (k < 40) begin
        send_item(OP_EXIT_START, cpu, 0, {$urandom, $urandom}, now_ns, sel_t'($urandom), 0);
        send_item(OP_EXIT, cpu, ($urandom_range(0, 1) != 0) ? hcall_vec : 8'($urandom),
                  h, {$urandom, $urandom}, sel_t'($urandom), 8'($urandom));
        send_item(OP_EXIT_END, cpu, 8'($urandom), h, now_ns + d, sel_t'($urandom), 0);
        i += 2;
      end else if (k < 55) begin
        send_item(OP_FAULT_START, cpu, 0, h, now_ns, sel_t'($urandom), 0);
        send_item(OP_FAULT_END, cpu, 0, h, now_ns + d, sel_t'($urandom), 0);
        i += 1;
      end else if (k < 85) begin
        read_bin(sel_t'($urandom), ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 80))
                                                                : 8'($urandom));
      end else if (k < 87) begin
        send_item(OP_CLEAR, cpu, 0, 0, 0, sel_t'($urandom), 0);
      end else begin
        op = op_t'($urandom_range(0, 7));
        send_item(op, cpu, 8'($urandom), h, {$urandom, $urandom}, sel_t'($urandom),
                  8'($urandom));
      end
      now_ns += 64'($urandom_range(0, 50000));
    end
    for (int b = 0; b < 80; b++) read_bin(sel_t'(b % 4), 8'($urandom_range(0, 70)));
    drain();
  endtask

  task automatic test_config_settings();
    write_reg(CFG_HCALL_VEC, 8'd0);
    write_reg(CFG_MAX_HCALL, 8'd255);
    write_reg(CFG_MAX_TRAP, 8'd255);
    test_random(400);
    write_reg(CFG_HCALL_VEC, 8'd255);
    write_reg(CFG_MAX_HCALL, 8'd0);
    write_reg(CFG_MAX_TRAP, 8'd0);
    test_random(300);
    write_reg(CFG_HCALL_VEC, 8'($urandom_range(0, 15)));
    write_reg(CFG_MAX_HCALL, 8'($urandom_range(1, 20)));
    write_reg(CFG_MAX_TRAP, 8'($urandom_range(1, 20)));
    test_random(300);
  endtask

  always @(posedge clk) begin
    bin_read_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_reads.size() == 0) begin
        report("unexpected result", out_count_value, 0);
      end else begin
        want = pending_reads.pop_front();
        if (out_count_value !== want.cnt) report("count_value", out_count_value, want.cnt);
        if (out_time_total_us !== want.tm) report("time_total_us", out_time_total_us, want.tm);
      end
    end
    if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 39) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(5, 30);
    end else begin
      out_stall <= ($urandom_range(0, 3) == 0);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("exit_cause_latency_histogram test failed");
      $finish;
    end
  end

  initial begin
    hcall_vec = 8'd31;
    max_hcall = 8'd63;
    max_trap = 8'd63;
    for (int c = 0; c < NUM_CPUS; c++) begin
      fault_stamp[c] = 0;
      exit_stamp[c] = 0;
      last_kind[c] = KIND_NONE;
      last_idx[c] = 0;
    end
    for (int i = 0; i < NUM_BINS; i++) begin
      hcall_cnt[i] = 0; trap_cnt[i] = 0; hcall_tm[i] = 0;
      trap_tm[i] = 0; fault_hist[i] = 0; exit_hist[i] = 0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random(200);
    test_config_settings();
    if (errors == 0 && pending_reads.size() == 0) begin
      $display("exit_cause_latency_histogram test passed");
    end else begin
      $display("exit_cause_latency_histogram test failed");
    end
    $finish;
  end
endmodule

// File: files.f
sv/echist_pkg.sv
sv/echist_div.sv
sv/exit_cause_latency_histogram.sv
verif/testbench.sv
